@@ sv/chained_hash_table_assert.svh @@
// Assertion macros for the chained hash table.
`ifndef CHAINED_HASH_TABLE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ASSERT_SVH
// Assert that a condition implies a property on the same edge.
`define CHT_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Assert that a condition implies a property on the next edge.
`define CHT_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

@@ sv/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants for the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;
endpackage

@@ sv/cht_ram.sv @@
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/chained_hash_table.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table
// Separate-chaining hash table with node pool in RAM.
// ----------------------------------------------------------------------------
// Channel | Ports                                   | Handshake
// request | in_command in_key in_key_length in_value| start & !busy
// result  | out_found out_read_value out_status     | out_strobe, 1 cycle
// config  | cfg_data                                | cfg_valid & cfg_ready
//
// Steps per request after the accepting edge: a remainder loop of one subtract
// of the bucket count per cycle (S_MOD), the head read (S_HRD, S_HWAIT), a read
// and a compare per chain node visited (S_NWAIT, S_NCHK), the apply (S_FDONE),
// S_FWAIT for a free-list pop or a delete behind a predecessor, then the result.
// A clear sweeps all heads in S_INIT, then gives its result (S_DONE).
// Reset runs the same sweep with no result; busy holds requests off meanwhile.
// The receiver cannot stall; results show for one cycle on out_strobe.
// ----------------------------------------------------------------------------
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = 128,
  parameter int POOL_NODES  = 256,
  parameter int KEY_BYTES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_key,
  input  logic [3:0]  in_key_length,
  input  logic [31:0] in_value,
  output logic        out_strobe,
  output logic        out_found,
  output logic [31:0] out_read_value,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
`include "chained_hash_table_assert.svh"

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int SW = 12;
  localparam int NODE_W = 64 + 4 + 32 + NW;
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
  localparam logic [SW-1:0] MAXB = SW'(MAX_BUCKETS);

  // FSM codes
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MOD    = 4'd2;
  localparam logic [3:0] S_HRD    = 4'd3;
  localparam logic [3:0] S_HWAIT  = 4'd4;
  localparam logic [3:0] S_NWAIT  = 4'd5;
  localparam logic [3:0] S_NCHK   = 4'd6;
  localparam logic [3:0] S_FWAIT  = 4'd7;
  localparam logic [3:0] S_FDONE  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    cmd_r;
  logic [63:0]   key_r;
  logic [3:0]    len_r;
  logic [31:0]   val_r;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [SW-1:0] div_r;
  logic [BW-1:0] bkt_r;
  logic [NW-1:0] cur_r, prev_r;
  logic [NW-1:0] head_r;
  logic [SW-1:0] steps_r;
  logic [NW-1:0] alloc_r, free_r;
  logic [7:0]    bcnt_r;
  logic [BW-1:0] clr_r;
  logic          found_r, status_r;
  logic [31:0]   rd_r;

  // Delete behind a predecessor rewrites prev's next field: keep both nodes.
  logic [NODE_W-1:0] prev_node_r, hit_node_r;
  logic              del_fix_r;
  logic              pop_r;

  // head RAM
  logic          h_we;
  logic [BW-1:0] h_waddr, h_raddr;
  logic [NW-1:0] h_wdata, h_rdata;
  logic          hr_we;
  logic [BW-1:0] hr_waddr;
  logic [NW-1:0] hr_wdata;
  cht_ram #(.WIDTH(NW), .DEPTH(1 << BW)) u_head (
    .clk, .we(hr_we), .waddr(hr_waddr), .wdata(hr_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  // node RAM: {next, value, len, key}
  logic              n_we;
  logic [IW-1:0]     n_waddr, n_raddr;
  logic [NODE_W-1:0] n_wdata, n_rdata;
  logic              nw_we;
  logic [IW-1:0]     nw_addr;
  logic [NODE_W-1:0] nw_data;
  cht_ram #(.WIDTH(NODE_W), .DEPTH(1 << IW)) u_node (
    .clk, .we(nw_we), .waddr(nw_addr), .wdata(nw_data), .raddr(n_raddr), .rdata(n_rdata)
  );
  logic [63:0]   nd_key;
  logic [3:0]    nd_len;
  logic [31:0]   nd_val;
  logic [NW-1:0] nd_next;
  assign {nd_next, nd_val, nd_len, nd_key} = n_rdata;

  // request decode: length clamp, key mask, byte sum
  logic [3:0]    len_c;
  logic [63:0]   key_c;
  logic [SW-1:0] sum_c;
  always_comb begin
    len_c = (in_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_key_length;
    key_c = '0;
    sum_c = SW'(1);
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len_c) begin
        key_c[i*8 +: 8] = in_key[i*8 +: 8];
        sum_c = sum_c + SW'(in_key[i*8 +: 8]);
      end
    end
  end

  // effective bucket count
  logic [SW-1:0] eff_b;
  always_comb begin
    eff_b = SW'(bcnt_r);
    if (bcnt_r == 8'd0) eff_b = SW'(1);
    if (SW'(bcnt_r) > MAXB) eff_b = MAXB;
  end

  logic hit_c;
  assign hit_c = (nd_len == len_r) && (nd_key == key_r);

  assign busy       = (state_r != S_IDLE);
  // config only between requests, never at an accepting edge
  assign cfg_ready  = (state_r == S_IDLE) && !start;

  // control and datapath
  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    h_we = 1'b0; h_waddr = bkt_r; h_wdata = NIL; h_raddr = bkt_r;
    n_we = 1'b0; n_waddr = cur_r[IW-1:0]; n_wdata = n_rdata; n_raddr = cur_r[IW-1:0];
    unique case (state_r)
      S_INIT: begin
        h_we = 1'b1; h_waddr = clr_r; h_wdata = NIL;
        // the reset sweep gives no result
        if (clr_r == BW'(MAX_BUCKETS - 1))
          state_nxt = (cmd_r == CMD_CLEAR) ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          sum_nxt = sum_c;
          state_nxt = (in_command == CMD_CLEAR) ? S_INIT : S_MOD;
        end
      end
      S_MOD: begin
        if (sum_r >= div_r) sum_nxt = sum_r - div_r;
        else state_nxt = S_HRD;
      end
      S_HRD: begin
        h_raddr = bkt_r;
        state_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        n_raddr = h_rdata[IW-1:0];
        state_nxt = (h_rdata < NIL) ? S_NWAIT : S_FDONE;
      end
      S_NWAIT: begin
        state_nxt = S_NCHK;
      end
      S_NCHK: begin
        if (hit_c) begin
          state_nxt = S_FDONE;
        end else begin
          n_raddr = nd_next[IW-1:0];
          state_nxt = (nd_next < NIL && steps_r < SW'(POOL_NODES - 1)) ? S_NWAIT : S_FDONE;
        end
      end
      S_FWAIT: begin
        state_nxt = S_DONE;
      end
      S_FDONE: begin
        // apply the command; n_rdata holds the hit node when found
        priority if (cmd_r == CMD_INSERT) begin
          if (found_r) begin
            n_we = 1'b1; n_waddr = cur_r[IW-1:0];
            n_wdata = {nd_next, val_r, nd_len, nd_key};
            state_nxt = S_DONE;
          end else if (free_r < NIL) begin
            n_raddr = free_r[IW-1:0];
            state_nxt = S_FWAIT;
          end else if (alloc_r < NIL) begin
            n_we = 1'b1; n_waddr = alloc_r[IW-1:0];
            n_wdata = {head_r, val_r, len_r, key_r};
            h_we = 1'b1; h_waddr = bkt_r; h_wdata = alloc_r;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (cmd_r == CMD_DELETE && found_r) begin
          if (prev_r < NIL) begin
            // prev skips the hit node
            n_we = 1'b1; n_waddr = prev_r[IW-1:0];
            n_wdata = {nd_next, prev_node_r[NODE_W-NW-1:0]};
            state_nxt = S_FWAIT;
          end else begin
            h_we = 1'b1; h_waddr = bkt_r; h_wdata = nd_next;
            n_we = 1'b1; n_waddr = cur_r[IW-1:0];
            n_wdata = {free_r, nd_val, nd_len, nd_key};
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cmd_r   <= CMD_INSERT;
      clr_r   <= '0;
      alloc_r <= '0;
      free_r  <= NIL;
      bcnt_r  <= 8'd128;
      del_fix_r <= 1'b0;
      pop_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      if (cfg_valid && cfg_ready) bcnt_r <= cfg_data;
      unique case (state_r)
        S_INIT: begin
          if (state_nxt != S_INIT) clr_r <= '0;
          else clr_r <= clr_r + BW'(1);
          alloc_r <= '0;
          free_r <= NIL;
          found_r <= 1'b0; status_r <= STATUS_DONE; rd_r <= '0;
        end
        S_IDLE: begin
          cmd_r <= in_command; key_r <= key_c; len_r <= len_c; val_r <= in_value;
          div_r <= eff_b;
          found_r <= 1'b0; status_r <= STATUS_DONE; rd_r <= '0;
          prev_r <= NIL; steps_r <= '0;
          del_fix_r <= 1'b0; pop_r <= 1'b0;
        end
        S_MOD: bkt_r <= sum_r[BW-1:0];
        S_HWAIT: begin
          head_r <= h_rdata;
          cur_r  <= h_rdata;
        end
        S_NCHK: begin
          if (hit_c) begin
            found_r <= 1'b1;
            hit_node_r <= n_rdata;
            if (cmd_r == CMD_READ) rd_r <= nd_val;
          end else begin
            prev_r <= cur_r;
            prev_node_r <= n_rdata;
            cur_r <= nd_next;
            steps_r <= steps_r + SW'(1);
          end
        end
        S_FDONE: begin
          if (cmd_r == CMD_INSERT && !found_r) begin
            if (free_r < NIL) pop_r <= 1'b1;
            else if (alloc_r < NIL) alloc_r <= alloc_r + NW'(1);
            else status_r <= STATUS_FULL;
          end
          if (cmd_r == CMD_DELETE && found_r) begin
            if (prev_r < NIL) del_fix_r <= 1'b1;
            else free_r <= cur_r;
          end
        end
        S_FWAIT: begin
          if (del_fix_r) free_r <= cur_r;
          else if (pop_r) free_r <= nd_next;
        end
        default: ;
      endcase
    end
  end

  // second write for free-list pop and delete with predecessor
  logic              w2_we;
  logic [IW-1:0]     w2_addr;
  logic [NODE_W-1:0] w2_data;
  always_comb begin
    w2_we = 1'b0; w2_addr = cur_r[IW-1:0]; w2_data = hit_node_r;
    if (state_r == S_FWAIT && pop_r) begin
      w2_we = 1'b1; w2_addr = free_r[IW-1:0];
      w2_data = {head_r, val_r, len_r, key_r};
    end else if (state_r == S_FWAIT && del_fix_r) begin
      w2_we = 1'b1; w2_addr = cur_r[IW-1:0];
      w2_data = {free_r, hit_node_r[NODE_W-NW-1:0]};
    end
  end

  // Node RAM port mux: the second write owns the port in FWAIT
  always_comb begin
    nw_we = n_we; nw_addr = n_waddr; nw_data = n_wdata;
    if (w2_we) begin
      nw_we = 1'b1; nw_addr = w2_addr; nw_data = w2_data;
    end
  end

  // head write for free-list pop
  logic hp_we;
  assign hp_we = (state_r == S_FWAIT) && pop_r;

  // head RAM port mux
  always_comb begin
    hr_we = h_we; hr_waddr = h_waddr; hr_wdata = h_wdata;
    if (hp_we) begin
      hr_we = 1'b1; hr_waddr = bkt_r; hr_wdata = free_r;
    end
  end

  // result
  assign out_strobe     = (state_r == S_DONE) && rst_n;
  assign out_found      = found_r;
  assign out_read_value = rd_r;
  assign out_status     = status_r;

  `CHT_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_strobe, busy, "strobe while idle")
  `CHT_ASSERT_NXT(a_one_result, clk, rst_n, out_strobe, !out_strobe, "double result")
  `CHT_ASSERT_IMP(a_full_flag, clk, rst_n, out_strobe && out_status, !out_found,
                  "full flagged on existing key")
endmodule

@@ tb/sv/chained_hash_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_table_tb
// Self-checking bench: drives insert/read/delete/clear requests with random
// keys and idle gaps across several bucket counts, predicts every result
// with a chained hash table kept in the bench, and compares field by field.
// ----------------------------------------------------------------------------
module chained_hash_table_tb;
  import cht_pkg::*;

  localparam int NUM_BUCKETS = 128;
  localparam int NUM_NODES   = 256;
  localparam int NO_NODE     = NUM_NODES;
  localparam longint CYCLE_LIMIT = 30_000_000;

  typedef struct {
    logic        found;
    logic [31:0] read_value;
    logic        status;
  } table_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow hash table plus the queue of pending results
  // --------------------------------------------------------------------------
  class hash_scoreboard;
    int unsigned   head[NUM_BUCKETS];
    logic [63:0]   node_key[NUM_NODES];
    logic [3:0]    node_len[NUM_NODES];
    logic [31:0]   node_val[NUM_NODES];
    int unsigned   node_link[NUM_NODES];
    int unsigned   alloc_top;
    int unsigned   free_head;
    logic [7:0]    buckets;
    table_result_t pending[$];
    int            errors;

    function void wipe();
      foreach (head[i]) head[i] = NO_NODE;
      alloc_top = 0;
      free_head = NO_NODE;
    endfunction

    function void reset_state();
      buckets = 8'd128;
      errors  = 0;
      wipe();
    endfunction

    function void set_buckets(logic [7:0] b);
      buckets = b;
    endfunction

    // Predict the result of one accepted request
    function void note_request(logic [1:0] cmd, logic [63:0] key_in,
                               logic [3:0] len_in, logic [31:0] val);
      int unsigned   len, divisor, sum, b, cur, prev, hit, n, steps;
      logic [63:0]   key;
      table_result_t r;
      r = '{1'b0, 32'd0, STATUS_DONE};
      len = (len_in > 8) ? 8 : len_in;
      key = (len >= 8) ? key_in : key_in & ((64'd1 << (8 * len)) - 64'd1);
      if (cmd == CMD_CLEAR) begin
        wipe();
      end else begin
        divisor = (buckets == 0) ? 1 : (buckets > NUM_BUCKETS) ? NUM_BUCKETS : buckets;
        sum = 1;
        for (int i = 0; i < len; i++) sum += key[8*i +: 8];
        b = sum % divisor;
        prev = NO_NODE;
        hit = NO_NODE;
        cur = head[b];
        steps = 0;
        while (steps < NUM_NODES && cur < NO_NODE) begin
          if (node_len[cur] == len && node_key[cur] == key) begin
            hit = cur;
            break;
          end
          prev = cur;
          cur = node_link[cur];
          steps++;
        end
        r.found = (hit < NO_NODE);
        case (cmd)
          CMD_INSERT: begin
            if (hit < NO_NODE) begin
              node_val[hit] = val;
            end else begin
              n = NO_NODE;
              if (free_head < NO_NODE) begin
                n = free_head;
                free_head = node_link[n];
              end else if (alloc_top < NUM_NODES) begin
                n = alloc_top;
                alloc_top++;
              end
              if (n < NO_NODE) begin
                node_key[n]  = key;
                node_len[n]  = 4'(len);
                node_val[n]  = val;
                node_link[n] = head[b];
                head[b]      = n;
              end else begin
                r.status = STATUS_FULL;
              end
            end
          end
          CMD_READ: begin
            if (hit < NO_NODE) r.read_value = node_val[hit];
          end
          default: begin
            if (hit < NO_NODE) begin
              if (prev < NO_NODE) node_link[prev] = node_link[hit];
              else head[b] = node_link[hit];
              node_link[hit] = free_head;
              free_head = hit;
            end
          end
        endcase
      end
      pending.push_back(r);
    endfunction

    // Compare one result against the oldest prediction
    function void check_result(logic found, logic [31:0] rv, logic status);
      table_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR unexpected result: found=%0b value=%h status=%0b",
                                   found, rv, status);
        return;
      end
      e = pending.pop_front();
      if (found !== e.found || rv !== e.read_value || status !== e.status) begin
        errors++;
        if (errors <= 10)
          $display("ERROR result: exp found=%0b value=%h status=%0b, got %0b %h %0b",
                   e.found, e.read_value, e.status, found, rv, status);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_READ;
  logic [63:0] in_key = '0;
  logic [3:0]  in_key_length = '0;
  logic [31:0] in_value = '0;
  logic        out_strobe;
  logic        out_found;
  logic [31:0] out_read_value;
  logic        out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  hash_scoreboard sb = new();
  longint cycles = 0;
  bit     allow_idle = 1'b1;

  // Key history for hits on existing entries
  logic [63:0] used_keys[$];
  logic [3:0]  used_lens[$];

  always #2 clk = ~clk;

  chained_hash_table uut (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_key, .in_key_length, .in_value,
    .out_strobe, .out_found, .out_read_value, .out_status,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_found, out_read_value, out_status);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("chained_hash_table: mismatch");
      $finish;
    end
  end

  // Issue one request and wait for it to be taken
  task automatic send_request(logic [1:0] cmd, logic [63:0] key, logic [3:0] len,
                              logic [31:0] val);
    if (allow_idle) begin
      while ($urandom_range(99) < 10) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_key        <= key;
    in_key_length <= len;
    in_value      <= val;
    do @(posedge clk); while (busy);
    sb.note_request(cmd, key, len, val);
  endtask

  // Wait until all results are in and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NUM_BUCKETS + 40) @(posedge clk);
  endtask

  task automatic write_buckets(logic [7:0] b);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_buckets(b);
  endtask

  // Build a key: reuse an earlier one (new junk above its length) or make one
  task automatic pick_key(bit fresh, bit short_keys, output logic [63:0] key,
                          output logic [3:0] len);
    int idx;
    if (!fresh && used_keys.size() != 0) begin
      idx = $urandom_range(used_keys.size() - 1);
      len = used_lens[idx];
      key = {$urandom, $urandom};
      for (int i = 0; i < 8; i++) if (i < len) key[8*i +: 8] = used_keys[idx][8*i +: 8];
      if (len == 8 && $urandom_range(3) == 0) len = 4'($urandom_range(15, 8));
    end else begin
      len = short_keys ? 4'($urandom_range(3)) :
            ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      key = {$urandom, $urandom};
      if ($urandom_range(9) < 7) begin
        // narrow alphabet makes collisions and chains likely
        for (int i = 0; i < 8; i++)
          key[8*i +: 8] = ($urandom_range(15) == 0) ? 8'h00 : 8'h61 + 8'($urandom_range(3));
      end
      if (used_keys.size() < 400) begin
        used_keys.push_back(key);
        used_lens.push_back(len > 8 ? 4'd8 : len);
      end
    end
  endtask

  task automatic random_phase(int count, bit fill, bit short_keys);
    logic [63:0] key;
    logic [3:0]  len;
    logic [1:0]  cmd;
    int          roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (fill) cmd = (roll < 85) ? CMD_INSERT : (roll < 95) ? CMD_READ : CMD_DELETE;
      else cmd = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_READ :
                 (roll < 99) ? CMD_DELETE : CMD_CLEAR;
      pick_key(fill ? ($urandom_range(9) < 8) : ($urandom_range(9) < 3), short_keys, key, len);
      send_request(cmd, key, len, $urandom);
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty keys, extremes, embedded zeros, over-long lengths
    send_request(CMD_READ,   64'd0, 4'd0, 32'd0);
    send_request(CMD_INSERT, 64'd0, 4'd0, 32'hFFFF_FFFF);
    send_request(CMD_READ,   64'hDEAD, 4'd0, 32'd0);
    send_request(CMD_INSERT, 64'd0, 4'd1, 32'h1234_5678);
    send_request(CMD_READ,   64'hFF00, 4'd1, 32'd0);
    send_request(CMD_INSERT, '1, 4'd8, 32'h3F80_0000);
    send_request(CMD_INSERT, '1, 4'd15, 32'd0);
    send_request(CMD_READ,   '1, 4'd9, 32'd0);
    send_request(CMD_INSERT, 64'h0061_0000_6200, 4'd6, 32'hAAAA_5555);
    send_request(CMD_READ,   64'h0061_0000_6200, 4'd6, 32'd0);
    send_request(CMD_READ,   64'h0061_0000_6200, 4'd5, 32'd0);
    send_request(CMD_DELETE, 64'h6362, 4'd2, 32'd0);
    send_request(CMD_DELETE, '1, 4'd8, 32'd0);
    send_request(CMD_READ,   '1, 4'd8, 32'd0);
    send_request(CMD_INSERT, 64'h6261, 4'd2, 32'h5555_AAAA);
    send_request(CMD_INSERT, 64'h6162, 4'd2, 32'h0000_0001);
    send_request(CMD_READ,   64'h6162, 4'd2, 32'd0);
    send_request(CMD_CLEAR,  '1, 4'd15, '1);
    send_request(CMD_READ,   64'h6261, 4'd2, 32'd0);
    send_request(CMD_DELETE, 64'd0, 4'd0, 32'd0);

    // Random phases over bucket counts; the first one overfills the pool
    random_phase(380, 1'b1, 1'b0);
    write_buckets(8'd1);
    random_phase(200, 1'b0, 1'b1);
    write_buckets(8'd0);
    random_phase(100, 1'b0, 1'b1);
    write_buckets(8'd255);
    allow_idle = 1'b0;
    random_phase(300, 1'b0, 1'b0);
    allow_idle = 1'b1;
    write_buckets(8'd7);
    random_phase(300, 1'b0, 1'b0);
    write_buckets(8'd64);
    random_phase(300, 1'b0, 1'b0);
    write_buckets(8'd128);
    random_phase(250, 1'b0, 1'b0);

    drain();
    if (sb.errors == 0) $display("chained_hash_table: match");
    else $display("chained_hash_table: mismatch");
    $finish;
  end
endmodule
